// ===== sv/fsts_pkg.sv =====
// Shared types and constants for the force servo translation step block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package fsts_pkg;

  // Fixed-point formats
  localparam int unsigned FORCE_W   = 32;  // signed Q16.16
  localparam int unsigned STIFF_W   = 31;  // unsigned Q15.16
  localparam int unsigned LEN_W     = 32;  // signed Q8.24
  localparam int unsigned DAMP_W    = 17;  // unsigned Q1.16
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned IVL_W     = 16;
  localparam int unsigned ERR_W     = FORCE_W + 1;
  localparam int unsigned QUO_W     = 31;  // quotients at or above 2^31 saturate
  localparam int unsigned FRAC_SH   = 24;  // Q16.16 / Q16.16 -> Q8.24

  localparam logic [DAMP_W-1:0] ONE_Q16         = 17'd65536;
  localparam logic [15:0]       NINE_TENTHS_Q16 = 16'd58982;

  localparam logic [DAMP_W-1:0] DAMP_RESET     = 17'd6554;
  localparam logic [30:0]       MAX_STEP_RESET = 31'd16777;
  localparam logic [IVL_W-1:0]  IVL_RESET      = 16'd1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 8'd5;

  typedef struct packed {
    logic        [31:0] step_number;
    logic signed [31:0] measured_force_x;
    logic signed [31:0] measured_force_y;
    logic signed [31:0] measured_force_z;
    logic        [30:0] stiffness_in_x;
    logic        [30:0] stiffness_in_y;
    logic        [30:0] stiffness_in_z;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
  } fsts_in_t;

  typedef struct packed {
    logic signed [31:0] new_position_x;
    logic signed [31:0] new_position_y;
    logic signed [31:0] new_position_z;
    logic signed [31:0] applied_move_x;
    logic signed [31:0] applied_move_y;
    logic signed [31:0] applied_move_z;
  } fsts_out_t;

  // Control shared by all three axis lanes
  typedef struct packed {
    logic              start;     // begin one item
    logic              load;      // refresh held stiffness from the item
    logic [DAMP_W-1:0] weight;    // 1 - damping, Q1.16
    logic [30:0]       max_step;  // unsigned Q7.24
  } fsts_lane_ctl_t;

endpackage
`default_nettype wire

// ===== sv/force_servo_translation_step.sv =====
// Force servo translation step: three axis lanes behind a serial interval test.
// Sequence: the interval test, then the lanes (each with a one-bit-per-cycle stiffness
// divider), then a merge into the output register, which raises output valid.
// A new item is taken only once the last is merged; a finished beat waits in the output register.
// Reset: synchronous; clears held stiffness and filtered translation, loads
// register defaults (target 0, damping 0.1, max step 0.001, interval 1).
`timescale 1ns / 1ps
`default_nettype none
module force_servo_translation_step
  import fsts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fsts_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fsts_out_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOD   = 4'b0010,
    S_RUN   = 4'b0100,
    S_MERGE = 4'b1000
  } top_state_t;

  top_state_t state;
  fsts_in_t   item;
  logic signed [FORCE_W-1:0] target_force_x;
  logic signed [FORCE_W-1:0] target_force_y;
  logic signed [FORCE_W-1:0] target_force_z;
  logic [DAMP_W-1:0]  damping_gain;
  logic [30:0]        max_step;
  logic [IVL_W-1:0]   stiffness_interval;
  logic [IVL_W-1:0]   ivl;
  logic               in_acc;
  logic               merge_go;
  logic               mod_done;
  logic               mod_zero;
  fsts_lane_ctl_t     lane_ctl;
  logic [2:0]         lane_done;
  logic signed [LEN_W-1:0] new_pos [3];
  logic signed [LEN_W-1:0] moves   [3];

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign merge_go  = (state == S_MERGE) && (!out_valid || out_ready);
  assign ivl       = (stiffness_interval == '0) ? IVL_W'(1) : stiffness_interval;

  // Lane control: weight is 1 - min(damping, 1)
  always_comb begin
    lane_ctl.start    = (state == S_MOD) && mod_done;
    lane_ctl.load     = mod_zero;
    lane_ctl.weight   = (damping_gain > ONE_Q16) ? '0 : DAMP_W'(ONE_Q16 - damping_gain);
    lane_ctl.max_step = max_step;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_force_x     <= '0;
      target_force_y     <= '0;
      target_force_z     <= '0;
      damping_gain       <= DAMP_RESET;
      max_step           <= MAX_STEP_RESET;
      stiffness_interval <= IVL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_X: target_force_x     <= cfg_data;
        CFG_TARGET_Y: target_force_y     <= cfg_data;
        CFG_TARGET_Z: target_force_z     <= cfg_data;
        CFG_DAMPING:  damping_gain       <= cfg_data[DAMP_W-1:0];
        CFG_MAX_STEP: max_step           <= cfg_data[30:0];
        CFG_INTERVAL: stiffness_interval <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item <= in_data;
    end
  end

  fsts_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .dividend (in_data.step_number),
    .divisor  (ivl),
    .done     (mod_done),
    .is_zero  (mod_zero)
  );

  fsts_lane u_lane_x (
    .clk (clk), .rst (rst), .ctl (lane_ctl),
    .measured_force (item.measured_force_x), .target_force (target_force_x),
    .stiffness_in (item.stiffness_in_x), .position (item.position_x),
    .done (lane_done[0]), .new_position (new_pos[0]), .applied_move (moves[0])
  );

  fsts_lane u_lane_y (
    .clk (clk), .rst (rst), .ctl (lane_ctl),
    .measured_force (item.measured_force_y), .target_force (target_force_y),
    .stiffness_in (item.stiffness_in_y), .position (item.position_y),
    .done (lane_done[1]), .new_position (new_pos[1]), .applied_move (moves[1])
  );

  fsts_lane u_lane_z (
    .clk (clk), .rst (rst), .ctl (lane_ctl),
    .measured_force (item.measured_force_z), .target_force (target_force_z),
    .stiffness_in (item.stiffness_in_z), .position (item.position_z),
    .done (lane_done[2]), .new_position (new_pos[2]), .applied_move (moves[2])
  );

  // Sequence control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // raise on a merge, drop once the waiting beat is taken
      out_valid <= merge_go || (out_valid && !out_ready);
      unique case (state)
        S_IDLE:  if (in_acc) state <= S_MOD;
        S_MOD:   if (mod_done) state <= S_RUN;
        S_RUN:   if (&lane_done) state <= S_MERGE;
        S_MERGE: if (merge_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Merge lane results into the output beat
  always_ff @(posedge clk) begin
    if (merge_go) begin
      out_data.new_position_x <= new_pos[0];
      out_data.new_position_y <= new_pos[1];
      out_data.new_position_z <= new_pos[2];
      out_data.applied_move_x <= moves[0];
      out_data.applied_move_y <= moves[1];
      out_data.applied_move_z <= moves[2];
    end
  end

  // Lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_done == 3'b000) || (lane_done == 3'b111))
    else $error("axis lanes finished out of step");

  // Interval test only finishes while waiting for it
  a_mod_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("interval test finished outside its state");

  // Lanes only finish while running
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> (state == S_RUN))
    else $error("lane result arrived outside run state");

  // Merge is entered from run only
  a_merge_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_MERGE) |-> $past(state == S_RUN))
    else $error("merge entered without a finished run");

endmodule
`default_nettype wire

// ===== sv/fsts_mod.sv =====
// Serial remainder unit: tests whether the step number is a multiple of the interval.
// Depends on fsts_pkg. One quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fsts_mod
  import fsts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [STEP_W-1:0] dividend,
  input  wire logic [IVL_W-1:0]  divisor,
  output logic                   done,
  output logic                   is_zero
);

  localparam int unsigned CNT_W = $clog2(STEP_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [STEP_W-1:0] dvd;
  logic [IVL_W-1:0]  dsr;
  logic [IVL_W-1:0]  rem;
  logic [IVL_W-1:0]  rem_next;
  logic [IVL_W:0]    rem_sh;
  logic              ge;

  // One restoring step
  always_comb begin
    rem_sh   = {rem, dvd[STEP_W-1]};
    ge       = rem_sh >= {1'b0, dsr};
    rem_next = ge ? IVL_W'(rem_sh - {1'b0, dsr}) : rem_sh[IVL_W-1:0];
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[STEP_W-2:0], 1'b0};
      rem <= rem_next;
      if (cnt == CNT_W'(STEP_W - 1)) begin
        is_zero <= (rem_next == '0);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/fsts_lane.sv =====
// One axis lane: force error, serial divide by stiffness, clamp, filter, position update.
// Depends on fsts_pkg. Holds the axis stiffness and filtered translation state.
`timescale 1ns / 1ps
`default_nettype none
module fsts_lane
  import fsts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire fsts_lane_ctl_t            ctl,
  input  wire logic signed [FORCE_W-1:0] measured_force,
  input  wire logic signed [FORCE_W-1:0] target_force,
  input  wire logic        [STIFF_W-1:0] stiffness_in,
  input  wire logic signed [LEN_W-1:0]   position,
  output logic                           done,
  output logic signed [LEN_W-1:0]        new_position,
  output logic signed [LEN_W-1:0]        applied_move
);

  localparam int unsigned CNT_W = $clog2(QUO_W);
  localparam int unsigned PMV_W = DAMP_W + 1 + LEN_W;  // 50
  localparam int unsigned PPV_W = LEN_W + 17;          // 49
  localparam int unsigned SUM_W = PMV_W + 1;           // 51
  localparam int unsigned SHR_W = SUM_W - 16;          // 35

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_DIV  = 6'b000010,
    L_SEL  = 6'b000100,
    L_MUL  = 6'b001000,
    L_SUM  = 6'b010000,
    L_POS  = 6'b100000
  } lane_state_t;

  lane_state_t state;
  logic [CNT_W-1:0]   cnt;
  logic [STIFF_W-1:0] held_stiffness;
  logic [STIFF_W-1:0] k_use;
  logic [STIFF_W-1:0] dsr;
  logic [QUO_W-1:0]   dvd;
  logic [QUO_W-1:0]   rem;
  logic [QUO_W-1:0]   quo;
  logic [QUO_W:0]     rem_sh;
  logic               ge;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]   mag;
  logic               neg;
  logic               err_zero;
  logic               sat_mode;
  logic [30:0]        mag_sel;
  logic signed [LEN_W-1:0] mv;
  logic signed [PMV_W-1:0] p_mv;
  logic signed [PPV_W-1:0] p_prev;
  logic signed [SUM_W-1:0] sum;
  logic signed [SHR_W-1:0] shr;
  logic signed [LEN_W:0]   psum;

  // Error and stiffness select at start
  always_comb begin
    err   = ERR_W'(measured_force) - ERR_W'(target_force);
    mag   = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    k_use = ctl.load ? stiffness_in : held_stiffness;
  end

  // One restoring divide step
  always_comb begin
    rem_sh = {rem, dvd[QUO_W-1]};
    ge     = rem_sh >= {1'b0, dsr};
  end

  // Clamp the magnitude; the sign is applied in L_SEL
  always_comb begin
    if (err_zero) begin
      mag_sel = '0;
    end else if (sat_mode || (quo > ctl.max_step)) begin
      mag_sel = ctl.max_step;
    end else begin
      mag_sel = quo;
    end
  end

  // Filter sum, floor by 2^16, and position sum
  always_comb begin
    sum  = SUM_W'(p_mv) + SUM_W'(p_prev);
    shr  = sum[SUM_W-1:16];
    psum = (LEN_W+1)'(position) + (LEN_W+1)'(applied_move);
  end

  // Sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= L_IDLE;
      done           <= 1'b0;
      cnt            <= '0;
      held_stiffness <= '0;
      applied_move   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (ctl.start) begin
            held_stiffness <= k_use;
            cnt            <= '0;
            state          <= L_DIV;
          end
        end
        L_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QUO_W - 1)) begin
            state <= L_SEL;
          end
        end
        L_SEL: state <= L_MUL;
        L_MUL: state <= L_SUM;
        L_SUM: begin
          if (shr > SHR_W'(signed'(32'sh7FFFFFFF))) begin
            applied_move <= 32'sh7FFFFFFF;
          end else if (shr < SHR_W'(signed'(-32'sh80000000))) begin
            applied_move <= -32'sh80000000;
          end else begin
            applied_move <= shr[LEN_W-1:0];
          end
          state <= L_POS;
        end
        L_POS: begin
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: begin
        if (ctl.start) begin
          neg      <= err[ERR_W-1];
          err_zero <= (err == '0);
          // quotient of 2^31 or more always clamps to the cap
          sat_mode <= (k_use == '0) || ({7'b0, mag[ERR_W-1:7]} >= ERR_W'(k_use));
          dsr      <= k_use;
          rem      <= QUO_W'(mag[ERR_W-1:7]);
          dvd      <= {mag[6:0], {FRAC_SH{1'b0}}};
          quo      <= '0;
        end
      end
      L_DIV: begin
        if (!sat_mode) begin
          rem <= ge ? QUO_W'(rem_sh - {1'b0, dsr}) : rem_sh[QUO_W-1:0];
          quo <= {quo[QUO_W-2:0], ge};
        end
        dvd <= {dvd[QUO_W-2:0], 1'b0};
      end
      L_SEL: begin
        mv <= neg ? -LEN_W'({1'b0, mag_sel}) : LEN_W'({1'b0, mag_sel});
      end
      L_MUL: begin
        p_mv   <= PMV_W'($signed({1'b0, ctl.weight})) * PMV_W'(mv);
        p_prev <= PPV_W'(applied_move) * PPV_W'($signed({1'b0, NINE_TENTHS_Q16}));
      end
      L_POS: begin
        if (psum[LEN_W] != psum[LEN_W-1]) begin
          new_position <= psum[LEN_W] ? -32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
          new_position <= psum[LEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
